### design/byte_string_text_encoder_macros.svh
// assertion macros used by the checker file of the text encoder
`ifndef BYTE_STRING_TEXT_ENCODER_MACROS_SVH
`define BYTE_STRING_TEXT_ENCODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BSTE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bste check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define BSTE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bste check failed");

`endif

### design/bste_pkg.sv
// shared constants, types and the hex digit table of the text encoder
`timescale 1ns / 1ps
package bste_pkg;

	// default store size in bytes per string
	localparam int unsigned MAX_BYTES_DEF = 32;

	// capacity register
	localparam int unsigned CAP_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd67;
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-1:0] REG_CAPACITY = 3'd0;

	// length of the emitted text, covers the largest store size
	localparam int unsigned LEN_W = 7;

	// characters
	localparam logic [7:0] HASH_CHAR   = 8'h23;
	localparam logic [7:0] QUOTE_CHAR  = 8'h22;
	localparam logic [7:0] BSLASH_CHAR = 8'h5C;
	localparam logic [7:0] ZERO_CHAR   = 8'h30;
	localparam logic [7:0] NINE_CHAR   = 8'h39;
	localparam logic [7:0] SPACE_CHAR  = 8'h20;
	localparam logic [7:0] BANG_CHAR   = 8'h21;
	localparam logic [7:0] TILDE_CHAR  = 8'h7E;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	localparam logic [7:0] HEX_DIGITS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	typedef enum logic [1:0] {
		FORM_VERBATIM = 2'd0,
		FORM_QUOTED   = 2'd1,
		FORM_HEX      = 2'd2
	} form_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_CAPACITY = 2'd1,
		ERR_TOO_LONG = 2'd2
	} err_t;

	// one finished string, handed from front to back
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
		form_t            form;
		err_t             err;
	} job_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return HEX_DIGITS[nib & NIBBLE_MASK];
	endfunction

endpackage

### design/bste_if.sv
// request channels of the text encoder: byte input and text output
`timescale 1ns / 1ps
interface bste_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;
	logic       empty_string;

	modport source(output valid, data_byte, final_byte, empty_string, input ready);
	modport sink(input valid, data_byte, final_byte, empty_string, output ready);
endinterface

interface bste_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_char;
	logic [7:0] second_char;
	logic [1:0] char_count;
	logic [1:0] form_code;
	logic [1:0] error_code;
	logic       last_result;

	modport source(output valid, first_char, second_char, char_count, form_code,
		error_code, last_result, input ready);
	modport sink(input valid, first_char, second_char, char_count, form_code,
		error_code, last_result, output ready);
endinterface

### design/byte_string_text_encoder.sv
// top level of the byte string text encoder
`timescale 1ns / 1ps
// Takes a byte string one byte per request and emits it as verbatim, quoted
// or hex text, up to two characters per result, or one error result when
// the string overflows the store or the text would not fit the capacity
// register (APB register 0). Loading accepts a byte whenever the queue has
// room. Each character of the text takes a byte store read, then the
// formatting step. The byte store has two banks and the two-entry queue
// holds up to two finished strings, so the next string loads while the
// previous one is still being emitted; input stalls only when both banks
// are taken.
module byte_string_text_encoder import bste_pkg::*; #(
	parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	bste_in_if.sink               byte_in,
	bste_out_if.source            text_out
);

	localparam int unsigned IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int unsigned RAM_DEPTH = 2 * (2 ** IDX_W);

	logic [CAP_W-1:0] capacity_q;
	logic             reg_hit;
	logic             push;
	job_t             push_job;
	logic             pop;
	job_t             head;
	queue_status_t    q_status;
	logic             wr_en;
	logic [IDX_W:0]   wr_addr;
	logic [7:0]       wr_data;
	logic [IDX_W:0]   rd_addr;
	logic [7:0]       rd_data;

	// configuration register, decoded on the word address
	assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_CAPACITY[APB_ADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {{(32 - CAP_W){1'b0}}, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// loading side
	bste_front #(
		.MAX_BYTES(MAX_BYTES),
		.IDX_W    (IDX_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.capacity(capacity_q),
		.q_status(q_status),
		.push    (push),
		.push_job(push_job),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// two-bank byte store
	bste_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// finished strings
	bste_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	// emitting side
	bste_back #(
		.IDX_W(IDX_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_status(q_status),
		.pop     (pop),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.text_out(text_out)
	);

endmodule

### design/bste_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module bste_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/bste_front.sv
// front: takes bytes, stores them, tracks the class flags, picks the form
`timescale 1ns / 1ps
module bste_front import bste_pkg::*; #(
	parameter int unsigned MAX_BYTES = MAX_BYTES_DEF,
	parameter int unsigned IDX_W     = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	bste_in_if.sink           byte_in,
	input  logic [CAP_W-1:0]  capacity,
	input  queue_status_t     q_status,
	output logic              push,
	output job_t              push_job,
	output logic              wr_en,
	output logic [IDX_W:0]    wr_addr,
	output logic [7:0]        wr_data
);

	localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

	logic [CNT_W-1:0] count_q;
	logic             plain_q;
	logic             digits_q;
	logic             blocked_q;
	logic             too_long_q;
	logic             first_hash_q;
	logic             last_hash_q;
	logic             bank_q;

	logic             accept;
	logic             end_str;
	logic             room;
	logic [7:0]       b;
	logic             b_vis;
	logic             b_digit;
	logic             b_blocked;
	logic             b_hash;
	logic [CNT_W-1:0] n_nx;
	logic             plain_nx;
	logic             digits_nx;
	logic             blocked_nx;
	logic             too_long_nx;
	logic             first_hash_nx;
	logic             last_hash_nx;
	logic [7:0]       n8;
	logic             verbatim_ok;
	form_t            form;
	logic [7:0]       need;
	logic [7:0]       len8;
	err_t             err;

	// a bank is free for loading while the queue has room
	assign byte_in.ready = !q_status.full;
	assign accept  = byte_in.valid && byte_in.ready;
	assign end_str = accept && (byte_in.empty_string || byte_in.final_byte);
	assign b       = byte_in.data_byte;
	assign room    = count_q < MAX_CNT;

	// byte classes
	assign b_vis     = (b >= BANG_CHAR) && (b <= TILDE_CHAR);
	assign b_digit   = (b >= ZERO_CHAR) && (b <= NINE_CHAR);
	assign b_blocked = (b < SPACE_CHAR) || (b > TILDE_CHAR) || (b == QUOTE_CHAR)
		|| (b == BSLASH_CHAR);
	assign b_hash    = b == HASH_CHAR;

	// flags with the current byte folded in
	always_comb begin
		n_nx          = count_q;
		plain_nx      = plain_q;
		digits_nx     = digits_q;
		blocked_nx    = blocked_q;
		too_long_nx   = too_long_q;
		first_hash_nx = first_hash_q;
		last_hash_nx  = last_hash_q;
		if (room) begin
			n_nx         = count_q + CNT_W'(1);
			plain_nx     = plain_q && b_vis;
			digits_nx    = digits_q && b_digit;
			blocked_nx   = blocked_q || b_blocked;
			last_hash_nx = b_hash;
			if (count_q == '0) begin
				first_hash_nx = b_hash;
			end
		end else begin
			too_long_nx = 1'b1;
		end
		// an empty marker drops everything loaded so far
		if (byte_in.empty_string) begin
			n_nx        = '0;
			plain_nx    = 1'b1;
			digits_nx   = 1'b1;
			blocked_nx  = 1'b0;
			too_long_nx = 1'b0;
		end
	end

	// form choice, needed capacity and text length
	always_comb begin
		n8          = 8'(n_nx);
		verbatim_ok = (n_nx != '0) && !(first_hash_nx && last_hash_nx) && plain_nx
			&& !digits_nx;
		if (verbatim_ok) begin
			form = FORM_VERBATIM;
			need = n8 + 8'd1;
			len8 = n8;
		end else if (!blocked_nx) begin
			form = FORM_QUOTED;
			need = n8 + 8'd3;
			len8 = n8 + 8'd2;
		end else begin
			form = FORM_HEX;
			need = (n8 << 1) + 8'd3;
			len8 = (n8 << 1) + 8'd2;
		end
		if (too_long_nx) begin
			err = ERR_TOO_LONG;
		end else if ({1'b0, capacity} < need) begin
			err = ERR_CAPACITY;
		end else begin
			err = ERR_NONE;
		end
	end

	assign push          = end_str;
	assign push_job.bank = bank_q;
	assign push_job.len  = len8[LEN_W-1:0];
	assign push_job.form = too_long_nx ? FORM_VERBATIM : form;
	assign push_job.err  = err;

	// byte store write
	assign wr_en   = accept && !byte_in.empty_string && room;
	assign wr_addr = {bank_q, count_q[IDX_W-1:0]};
	assign wr_data = b;

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			plain_q      <= 1'b1;
			digits_q     <= 1'b1;
			blocked_q    <= 1'b0;
			too_long_q   <= 1'b0;
			first_hash_q <= 1'b0;
			last_hash_q  <= 1'b0;
			bank_q       <= 1'b0;
		end else if (end_str) begin
			count_q      <= '0;
			plain_q      <= 1'b1;
			digits_q     <= 1'b1;
			blocked_q    <= 1'b0;
			too_long_q   <= 1'b0;
			first_hash_q <= 1'b0;
			last_hash_q  <= 1'b0;
			bank_q       <= !bank_q;
		end else if (accept) begin
			count_q      <= n_nx;
			plain_q      <= plain_nx;
			digits_q     <= digits_nx;
			blocked_q    <= blocked_nx;
			too_long_q   <= too_long_nx;
			first_hash_q <= first_hash_nx;
			last_hash_q  <= last_hash_nx;
		end
	end

endmodule

### design/bste_queue.sv
// two-entry queue of finished strings between front and back
`timescale 1ns / 1ps
module bste_queue import bste_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  job_t          push_job,
	input  logic          pop,
	output job_t          head,
	output queue_status_t status
);

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = count_q == 2'd2;
	assign status.empty = count_q == 2'd0;

	// entry payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/bste_back.sv
// back: walks a stored string and emits its text up to two characters a result
`timescale 1ns / 1ps
module bste_back import bste_pkg::*; #(
	parameter int unsigned IDX_W = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  job_t          head,
	input  queue_status_t q_status,
	output logic          pop,
	output logic [IDX_W:0] rd_addr,
	input  logic [7:0]    rd_data,
	bste_out_if.source    text_out
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CHAR,
		ST_ERROR
	} state_t;

	state_t           state_q;
	logic [LEN_W-1:0] pos_q;
	logic [7:0]       held_q;
	logic             out_valid_q;
	logic [7:0]       first_q;
	logic [7:0]       second_q;
	logic [1:0]       count_q;
	logic [1:0]       form_q;
	logic [1:0]       err_q;
	logic             last_q;

	logic             slot_free;
	logic             last_pos;
	logic             edge_pos;
	logic [LEN_W-1:0] idx;
	logic [7:0]       ch;
	logic             emit;
	logic             err_emit;
	logic             load_out;

	assign slot_free = !out_valid_q || text_out.ready;
	assign last_pos  = pos_q == (head.len - LEN_W'(1));
	assign edge_pos  = (pos_q == '0) || last_pos;

	// store index of the current text position
	always_comb begin
		case (head.form)
			FORM_VERBATIM: idx = pos_q;
			FORM_QUOTED:   idx = pos_q - LEN_W'(1);
			FORM_HEX:      idx = (pos_q - LEN_W'(1)) >> 1;
			default:       idx = pos_q;
		endcase
	end
	assign rd_addr = {head.bank, idx[IDX_W-1:0]};

	// character at the current position
	always_comb begin
		case (head.form)
			FORM_VERBATIM: ch = rd_data;
			FORM_QUOTED:   ch = edge_pos ? QUOTE_CHAR : rd_data;
			FORM_HEX:      ch = edge_pos ? HASH_CHAR
				: hex_char(pos_q[0] ? rd_data[7:4] : rd_data[3:0]);
			default:       ch = rd_data;
		endcase
	end

	// a result goes out on odd positions and on a lone last character
	assign emit     = (state_q == ST_CHAR) && slot_free && (pos_q[0] || last_pos);
	assign err_emit = (state_q == ST_ERROR) && slot_free;
	assign load_out = emit || err_emit;
	assign pop      = (emit && last_pos) || err_emit;

	assign text_out.valid       = out_valid_q;
	assign text_out.first_char  = first_q;
	assign text_out.second_char = second_q;
	assign text_out.char_count  = count_q;
	assign text_out.form_code   = form_q;
	assign text_out.error_code  = err_q;
	assign text_out.last_result = last_q;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
			first_q     <= '0;
			second_q    <= '0;
			count_q     <= '0;
			form_q      <= '0;
			err_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (text_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					pos_q <= '0;
					if (!q_status.empty) begin
						state_q <= (head.err != ERR_NONE) ? ST_ERROR : ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_CHAR;
				end
				ST_CHAR: begin
					if (!pos_q[0] && !last_pos) begin
						held_q  <= ch;
						pos_q   <= pos_q + LEN_W'(1);
						state_q <= ST_FETCH;
					end else if (slot_free) begin
						first_q     <= pos_q[0] ? held_q : ch;
						second_q    <= pos_q[0] ? ch : 8'd0;
						count_q     <= pos_q[0] ? 2'd2 : 2'd1;
						form_q      <= head.form;
						err_q       <= ERR_NONE;
						last_q      <= last_pos;
						pos_q       <= pos_q + LEN_W'(1);
						state_q     <= last_pos ? ST_IDLE : ST_FETCH;
					end
				end
				ST_ERROR: begin
					if (slot_free) begin
						first_q     <= 8'd0;
						second_q    <= 8'd0;
						count_q     <= 2'd0;
						form_q      <= head.form;
						err_q       <= head.err;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/bste_checker.sv
// port-level checks of the text encoder and their binding
`timescale 1ns / 1ps
`include "byte_string_text_encoder_macros.svh"
module bste_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] first_char,
	input logic [7:0] second_char,
	input logic [1:0] char_count,
	input logic [1:0] form_code,
	input logic [1:0] error_code,
	input logic       last_result
);

	// a stalled result holds
	`BSTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(first_char) && $stable(second_char) && $stable(char_count) && $stable(last_result))

	// an error result is alone, empty and last
	`BSTE_ASSERT_NOW(a_err_last, out_valid && (error_code != 2'd0), last_result && (char_count == 2'd0) && (first_char == 8'd0))

	// a normal result carries one or two characters
	`BSTE_ASSERT_NOW(a_count_ok, out_valid && (error_code == 2'd0), (char_count == 2'd1) || (char_count == 2'd2))

	// an overflow error reports the verbatim form code
	`BSTE_ASSERT_NOW(a_too_long_form, out_valid && (error_code == 2'd2), form_code == 2'd0)

endmodule

bind byte_string_text_encoder bste_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (text_out.valid),
	.out_ready  (text_out.ready),
	.first_char (text_out.first_char),
	.second_char(text_out.second_char),
	.char_count (text_out.char_count),
	.form_code  (text_out.form_code),
	.error_code (text_out.error_code),
	.last_result(text_out.last_result)
);

### tb/sv/tb_byte_string_text_encoder.sv
// self-checking testbench of the byte string text encoder
`timescale 1ns / 1ps
module tb_byte_string_text_encoder;
	import bste_pkg::*;

	localparam int unsigned STORE_DEPTH   = MAX_BYTES_DEF;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT   = 2000000;
	localparam int unsigned MAX_REPORTS   = 40;
	localparam logic [7:0]  UPPER_A       = 8'h41;

	// content classes of generated strings
	typedef enum int {
		CLS_DIGIT,
		CLS_GRAPH,
		CLS_TEXT,
		CLS_ANY,
		CLS_MIXED
	} byte_class_t;

	// how a generated string is closed
	typedef enum int {
		END_FINAL,
		END_ABORT,
		END_EMPTY
	} string_end_t;

	// one result as the encoder should emit it
	typedef struct {
		logic [7:0] first_char;
		logic [7:0] second_char;
		logic [1:0] char_count;
		form_t      form;
		err_t       err;
		logic       last;
	} text_chunk_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bste_in_if  byte_in();
	bste_out_if text_out();

	byte_string_text_encoder uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.byte_in (byte_in),
		.text_out(text_out)
	);

	// encoder state as the testbench tracks it
	logic [7:0]       str_bytes [STORE_DEPTH];
	int unsigned      str_len;
	logic             str_plain;
	logic             str_digits;
	logic             str_blocked;
	logic             str_overflow;
	logic [CAP_W-1:0] cap_value;

	text_chunk_t pending_text[$];

	int unsigned mismatches;
	int unsigned bytes_accepted;
	int unsigned strings_done;
	int unsigned chunks_checked;
	int unsigned verbatim_strings;
	int unsigned quoted_strings;
	int unsigned hex_strings;
	int unsigned capacity_errors;
	int unsigned overflow_errors;
	int unsigned cycles;
	bit          src_idle_on;
	bit          sink_idle_on;

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial clk = 1'b0;

	// random gap length: mostly none or short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] nibble_char(input logic [3:0] nib);
		if (nib < 4'd10)
			return ZERO_CHAR + nib;
		else
			return UPPER_A + (nib - 4'd10);
	endfunction

	function automatic void clear_string_state();
		str_len      = 0;
		str_plain    = 1'b1;
		str_digits   = 1'b1;
		str_blocked  = 1'b0;
		str_overflow = 1'b0;
	endfunction

	// store one byte and update the form flags
	function automatic void absorb_byte(input logic [7:0] b);
		if (str_len >= STORE_DEPTH) begin
			str_overflow = 1'b1;
			return;
		end
		str_bytes[str_len] = b;
		str_len++;
		if (b < BANG_CHAR || b > TILDE_CHAR)
			str_plain = 1'b0;
		if (b < ZERO_CHAR || b > NINE_CHAR)
			str_digits = 1'b0;
		if (b < SPACE_CHAR || b > TILDE_CHAR || b == QUOTE_CHAR || b == BSLASH_CHAR)
			str_blocked = 1'b1;
	endfunction

	function automatic void push_error(input form_t form, input err_t err);
		text_chunk_t c;
		c.first_char  = 8'h00;
		c.second_char = 8'h00;
		c.char_count  = 2'd0;
		c.form        = form;
		c.err         = err;
		c.last        = 1'b1;
		pending_text.push_back(c);
	endfunction

	// choose the text form of the finished string and queue its results
	function automatic void encode_string();
		logic [7:0]  chars[$];
		form_t       form;
		int unsigned need;
		text_chunk_t c;
		strings_done++;
		if (str_overflow) begin
			overflow_errors++;
			push_error(FORM_VERBATIM, ERR_TOO_LONG);
			return;
		end
		if (str_len > 0 && !(str_bytes[0] == HASH_CHAR && str_bytes[str_len-1] == HASH_CHAR)
			&& str_plain && !str_digits) begin
			form = FORM_VERBATIM;
			need = str_len + 1;
		end else if (!str_blocked) begin
			form = FORM_QUOTED;
			need = str_len + 3;
		end else begin
			form = FORM_HEX;
			need = 2 * str_len + 3;
		end
		if (cap_value < need) begin
			capacity_errors++;
			push_error(form, ERR_CAPACITY);
			return;
		end
		case (form)
			FORM_VERBATIM: begin
				verbatim_strings++;
				for (int i = 0; i < str_len; i++)
					chars.push_back(str_bytes[i]);
			end
			FORM_QUOTED: begin
				quoted_strings++;
				chars.push_back(QUOTE_CHAR);
				for (int i = 0; i < str_len; i++)
					chars.push_back(str_bytes[i]);
				chars.push_back(QUOTE_CHAR);
			end
			default: begin
				hex_strings++;
				chars.push_back(HASH_CHAR);
				for (int i = 0; i < str_len; i++) begin
					chars.push_back(nibble_char(str_bytes[i][7:4]));
					chars.push_back(nibble_char(str_bytes[i][3:0]));
				end
				chars.push_back(HASH_CHAR);
			end
		endcase
		// two characters per result, the last one may carry one
		for (int i = 0; i < chars.size(); i += 2) begin
			c.first_char  = chars[i];
			c.second_char = (i + 1 < chars.size()) ? chars[i+1] : 8'h00;
			c.char_count  = (i + 1 < chars.size()) ? 2'd2 : 2'd1;
			c.form        = form;
			c.err         = ERR_NONE;
			c.last        = (i + 2 >= chars.size());
			pending_text.push_back(c);
		end
	endfunction

	// effect of one accepted request
	function automatic void record_request(input logic [7:0] d, input logic fin,
		input logic emp);
		if (emp) begin
			clear_string_state();
		end else begin
			absorb_byte(d);
			if (!fin)
				return;
		end
		encode_string();
		clear_string_state();
	endfunction

	function automatic void check_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
		end
	endfunction

	// compare each accepted result with the oldest pending one
	always @(posedge clk) begin
		text_chunk_t want;
		if (arst_n === 1'b1 && text_out.valid === 1'b1 && text_out.ready === 1'b1) begin
			if (pending_text.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: no result expected, actual %0h %0h count %0d err %0d",
						$time, text_out.first_char, text_out.second_char,
						text_out.char_count, text_out.error_code);
			end else begin
				want = pending_text.pop_front();
				chunks_checked++;
				check_field("first_char", want.first_char, text_out.first_char);
				check_field("second_char", want.second_char, text_out.second_char);
				check_field("char_count", want.char_count, text_out.char_count);
				check_field("form_code", want.form, text_out.form_code);
				check_field("error_code", want.err, text_out.error_code);
				check_field("last_result", want.last, text_out.last_result);
			end
		end
	end

	// output side back-pressure
	initial begin
		int unsigned hold;
		hold = 0;
		text_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold != 0) begin
				text_out.ready <= 1'b0;
				hold--;
			end else begin
				text_out.ready <= 1'b1;
				if (sink_idle_on && $urandom_range(0, 3) == 0)
					hold = pick_gap();
			end
		end
	end

	// run guard
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("byte_string_text_encoder regression: fail");
		$finish;
	end

	// one request on the byte channel
	task automatic send_byte(input logic [7:0] d, input logic fin, input logic emp);
		int unsigned gap;
		gap = src_idle_on ? pick_gap() : 0;
		if (gap != 0) begin
			byte_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_in.valid        <= 1'b1;
		byte_in.data_byte    <= d;
		byte_in.final_byte   <= fin;
		byte_in.empty_string <= emp;
		do
			@(posedge clk);
		while (byte_in.ready !== 1'b1);
		bytes_accepted++;
		record_request(d, fin, emp);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1, 1'b0);
	endtask

	// stop sending and let every pending result come out
	task automatic wait_until_idle();
		byte_in.valid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
		input logic [31:0] data, output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// write the capacity register and read it back
	task automatic set_capacity(input int unsigned value);
		logic [31:0] rdata;
		wait_until_idle();
		apb_access(1'b1, REG_CAPACITY, value, rdata);
		cap_value = CAP_W'(value);
		apb_access(1'b0, REG_CAPACITY, 32'd0, rdata);
		if (rdata[CAP_W-1:0] !== cap_value) begin
			mismatches++;
			$display("%0t: capacity readback expected %0d, actual %0d", $time,
				cap_value, rdata[CAP_W-1:0]);
		end
	endtask

	function automatic logic [7:0] pick_byte(input byte_class_t cls);
		logic [7:0] b;
		case (cls)
			CLS_DIGIT: b = ZERO_CHAR + 8'($urandom_range(0, 9));
			CLS_GRAPH: b = 8'($urandom_range(BANG_CHAR, TILDE_CHAR));
			CLS_TEXT: begin
				b = 8'($urandom_range(SPACE_CHAR, TILDE_CHAR));
				if (b == QUOTE_CHAR || b == BSLASH_CHAR)
					b = SPACE_CHAR;
			end
			CLS_ANY: b = 8'($urandom_range(0, 255));
			default: begin
				case ($urandom_range(0, 11))
					0: b = QUOTE_CHAR;
					1: b = BSLASH_CHAR;
					2: b = 8'($urandom_range(0, 8'h1F));
					default: b = 8'($urandom_range(BANG_CHAR, TILDE_CHAR));
				endcase
			end
		endcase
		return b;
	endfunction

	// one string of random content, optionally framed by hash marks
	task automatic send_string(input int unsigned len, input byte_class_t cls,
		input bit framed, input string_end_t ending);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = pick_byte(cls);
			if (framed && (i == 0 || i == len - 1))
				b = HASH_CHAR;
			send_byte(b, ending == END_FINAL && i == len - 1, 1'b0);
		end
		if (ending != END_FINAL)
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	// each form, the flag corner cases and the empty marker
	task automatic test_text_forms();
		set_capacity(CAP_RESET);
		send_text("a");
		send_text("5");
		send_text(" ");
		send_text("~");
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte(8'h7F, 1'b1, 1'b0);
		send_byte(QUOTE_CHAR, 1'b1, 1'b0);
		send_byte(BSLASH_CHAR, 1'b1, 1'b0);
		// a lone hash both starts and ends the string
		send_text("#");
		send_text("#a#");
		send_text("#ab");
		send_text("90");
		send_byte(8'hA5, 1'b0, 1'b1);
		// empty marker discards loaded bytes, and wins over final
		send_byte("x", 1'b0, 1'b0);
		send_byte(8'h5A, 1'b0, 1'b1);
		send_byte("y", 1'b0, 1'b0);
		send_byte(8'h00, 1'b1, 1'b1);
	endtask

	// capacity right at and just under what each form needs
	task automatic test_capacity_edges();
		int unsigned caps[8];
		caps = '{0, 1, 2, 3, 4, 5, 6, 7};
		foreach (caps[k]) begin
			set_capacity(caps[k]);
			send_text("ab");
			send_text("12");
			send_byte(8'h00, 1'b0, 1'b0);
			send_byte(8'hFF, 1'b1, 1'b0);
			send_byte(8'h00, 1'b0, 1'b1);
		end
	endtask

	// full store, one byte past it, and overflow against capacity errors
	task automatic test_store_limit();
		set_capacity(CAP_RESET);
		for (int i = 0; i < STORE_DEPTH; i++)
			send_byte(8'($urandom_range(8'h80, 8'hFF)), i == STORE_DEPTH - 1, 1'b0);
		send_string(STORE_DEPTH + 1, CLS_GRAPH, 1'b0, END_FINAL);
		set_capacity(CAP_RESET - 1);
		for (int i = 0; i < STORE_DEPTH; i++)
			send_byte(8'($urandom_range(0, 8'h1F)), i == STORE_DEPTH - 1, 1'b0);
		set_capacity(0);
		send_string(STORE_DEPTH + 1, CLS_DIGIT, 1'b0, END_FINAL);
		send_string(STORE_DEPTH + 1, CLS_GRAPH, 1'b0, END_ABORT);
	endtask

	// random strings over several capacity settings
	task automatic test_random_strings();
		int unsigned caps[6];
		int unsigned quota[6];
		int unsigned start;
		int unsigned len;
		int unsigned r;
		string_end_t ending;
		caps  = '{67, 40, 20, 9, 0, 67};
		quota = '{30, 12, 12, 12, 6, 13};
		foreach (caps[p]) begin
			set_capacity(caps[p]);
			src_idle_on  = (p != 1);
			sink_idle_on = (p != 2);
			start = bytes_accepted;
			while (bytes_accepted - start < quota[p]) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					len = $urandom_range(1, 6);
				else if (r < 90)
					len = $urandom_range(7, 20);
				else if (r < 98)
					len = $urandom_range(21, STORE_DEPTH);
				else
					len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
				r = $urandom_range(0, 99);
				if (r < 86) begin
					ending = END_FINAL;
				end else if (r < 93) begin
					ending = END_ABORT;
				end else begin
					ending = END_EMPTY;
					len = 0;
				end
				send_string(len, byte_class_t'($urandom_range(CLS_DIGIT, CLS_MIXED)),
					$urandom_range(0, 5) == 0, ending);
			end
		end
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	initial begin
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		byte_in.valid        = 1'b0;
		byte_in.data_byte    = 8'h00;
		byte_in.final_byte   = 1'b0;
		byte_in.empty_string = 1'b0;
		mismatches       = 0;
		bytes_accepted   = 0;
		strings_done     = 0;
		chunks_checked   = 0;
		verbatim_strings = 0;
		quoted_strings   = 0;
		hex_strings      = 0;
		capacity_errors  = 0;
		overflow_errors  = 0;
		src_idle_on      = 1'b1;
		sink_idle_on     = 1'b1;
		cap_value        = CAP_RESET;
		clear_string_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_text_forms();
		test_capacity_edges();
		test_store_limit();
		test_random_strings();
		wait_until_idle();

		$display("strings: %0d verbatim, %0d quoted, %0d hex, %0d over capacity, %0d too long",
			verbatim_strings, quoted_strings, hex_strings, capacity_errors, overflow_errors);
		$display("%0d byte requests in, %0d text results checked, %0d mismatches",
			bytes_accepted, chunks_checked, mismatches);
		if (mismatches == 0)
			$display("byte_string_text_encoder regression: pass");
		else
			$display("byte_string_text_encoder regression: fail");
		$finish;
	end

endmodule
